// File: rtl/core/ibus_pkg.sv
// Shared types, constants and control structs of the servo frame receiver.
`timescale 1ns / 1ps

package ibus_pkg;

  // Frame layout.
  localparam int unsigned FRAME_LENGTH  = 32;
  localparam int unsigned CHANNEL_COUNT = 14;
  localparam int unsigned POS_W         = 5;
  localparam int unsigned CHAN_IDX_W    = 4;
  localparam int unsigned CFG_IDX_W     = 4;

  localparam logic [7:0]            HDR_FIRST  = 8'h20;
  localparam logic [7:0]            HDR_SECOND = 8'h40;
  localparam logic [15:0]           CKS_INIT   = 16'hFFFF;
  // Running checksum once both header bytes have been taken off.
  localparam logic [15:0]           CKS_START  = CKS_INIT - {8'h00, HDR_FIRST}
                                                 - {8'h00, HDR_SECOND};
  localparam logic [15:0]           SAT_MAX    = 16'hFFFF;
  localparam logic [POS_W-1:0]      POS_LAST   = POS_W'(FRAME_LENGTH - 1);
  localparam logic [POS_W-1:0]      POS_CKS_LO = POS_W'(FRAME_LENGTH - 2);
  localparam logic [CHAN_IDX_W-1:0] LAST_CHAN  = CHAN_IDX_W'(CHANNEL_COUNT - 1);

  // Input beat kinds.
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SANITY_MIN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SANITY_MAX = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STREAK = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = CFG_IDX_W'(3);

  // Configuration reset values.
  localparam logic [15:0] RST_SANITY_MIN = 16'd900;
  localparam logic [15:0] RST_SANITY_MAX = 16'd2100;
  localparam logic [15:0] RST_MAX_STREAK = 16'd3;
  localparam logic [15:0] RST_TIMEOUT    = 16'd100;

  typedef enum logic [1:0] {
    RES_CHANNEL    = 2'd0,
    RES_CKSUM_FAIL = 2'd1,
    RES_SANITY     = 2'd2,
    RES_TIMEOUT    = 2'd3
  } res_kind_e;

  typedef enum logic [1:0] {
    LINK_IDLE     = 2'd0,
    LINK_ACTIVE   = 2'd1,
    LINK_DEGRADED = 2'd2,
    LINK_FAILSAFE = 2'd3
  } link_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [3:0]  channel_index;
    logic [15:0] channel_value;
    logic        last;
    logic [1:0]  link_state;
    logic [15:0] fail_streak;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                  take;
    logic                  finish;
    logic                  out_load;
    res_kind_e             out_kind;
    logic [CHAN_IDX_W-1:0] chan_idx;
    logic                  out_last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic tick_fire;
    logic frame_end;
    logic cks_ok;
    logic sane_ok;
  } sts_t;

endpackage

// File: rtl/core/ibus_ctrl.sv
// Controller state machine: input acceptance, frame verdict and result sequencing.
`timescale 1ns / 1ps

module ibus_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  ibus_pkg::sts_t sts_i,
  output ibus_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_STATUS,
    S_CREAD,
    S_CEMIT
  } state_e;

  state_e                          state_q, state_d;
  ibus_pkg::res_kind_e             kind_q, kind_d;
  logic [ibus_pkg::CHAN_IDX_W-1:0] chan_q, chan_d;
  logic                            out_valid_q, out_valid_d;
  logic                            out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  // Next state and commands.
  always_comb begin
    state_d         = state_q;
    kind_d          = kind_q;
    chan_d          = chan_q;
    cmd_o.take      = 1'b0;
    cmd_o.finish    = 1'b0;
    cmd_o.out_load  = 1'b0;
    cmd_o.out_kind  = kind_q;
    cmd_o.chan_idx  = chan_q;
    cmd_o.out_last  = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (sts_i.tick_fire) begin
            kind_d  = ibus_pkg::RES_TIMEOUT;
            state_d = S_STATUS;
          end else if (sts_i.frame_end) begin
            state_d = S_EVAL;
          end
        end
      end
      S_EVAL: begin
        cmd_o.finish = 1'b1;
        if (!sts_i.cks_ok) begin
          kind_d  = ibus_pkg::RES_CKSUM_FAIL;
          state_d = S_STATUS;
        end else if (!sts_i.sane_ok) begin
          kind_d  = ibus_pkg::RES_SANITY;
          state_d = S_STATUS;
        end else begin
          chan_d  = '0;
          state_d = S_CREAD;
        end
      end
      S_STATUS: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_CREAD: begin
        // The channel store answers in the cycle after the address is shown.
        state_d = S_CEMIT;
      end
      S_CEMIT: begin
        cmd_o.out_kind = ibus_pkg::RES_CHANNEL;
        cmd_o.out_last = (chan_q == ibus_pkg::LAST_CHAN);
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          if (chan_q == ibus_pkg::LAST_CHAN) begin
            state_d = S_IDLE;
          end else begin
            chan_d  = chan_q + 1'b1;
            state_d = S_CREAD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // The output register is full until its beat is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      kind_q      <= ibus_pkg::RES_CHANNEL;
      chan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      chan_q      <= chan_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: rtl/core/ibus_dp.sv
// Datapath: configuration, byte sync, running checksum, channel store and link state.
`timescale 1ns / 1ps

module ibus_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ibus_pkg::in_item_t               in_data_i,
  input  logic                             cfg_we_i,
  input  logic [ibus_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [15:0]                      cfg_data_i,
  input  ibus_pkg::cmd_t                   cmd_i,
  output ibus_pkg::sts_t                   sts_o,
  output ibus_pkg::out_item_t              out_data_o
);

  // Configuration registers.
  logic [15:0] min_q, max_q, streak_max_q, timeout_q;

  // Frame and link state.
  logic [ibus_pkg::POS_W-1:0] pos_q, pos_d;
  logic [15:0]                acc_q, acc_d;
  logic [7:0]                 lo_q, lo_d;
  logic                       sane_q, sane_d;
  logic                       cks_ok_q, cks_ok_d;
  ibus_pkg::link_e            link_q, link_d;
  logic                       seen_q, seen_d;
  logic [15:0]                streak_q, streak_d;
  logic [15:0]                ms_q, ms_d;

  // Channel store.
  logic [15:0]                     chan_mem [ibus_pkg::CHANNEL_COUNT];
  logic [15:0]                     rd_q;
  logic                            mem_we;
  logic [ibus_pkg::CHAN_IDX_W-1:0] mem_waddr;

  ibus_pkg::out_item_t out_q;

  logic [7:0]  b;
  logic [15:0] word;
  logic [16:0] elapsed;
  logic [15:0] streak_inc;
  logic        is_tick;

  assign b          = in_data_i.byte_value;
  assign is_tick    = (in_data_i.kind == ibus_pkg::KIND_TICK);
  assign word       = {b, lo_q};
  assign elapsed    = {1'b0, ms_q} + 17'd1;
  assign streak_inc = (streak_q == ibus_pkg::SAT_MAX) ? streak_q : streak_q + 16'd1;
  assign mem_waddr  = pos_q[ibus_pkg::POS_W-1:1] - 4'd1;

  // Status toward the controller.
  assign sts_o.tick_fire = is_tick && seen_q && (elapsed > {1'b0, timeout_q})
                           && (link_q != ibus_pkg::LINK_FAILSAFE);
  assign sts_o.frame_end = !is_tick && (pos_q == ibus_pkg::POS_LAST);
  assign sts_o.cks_ok    = cks_ok_q;
  assign sts_o.sane_ok   = sane_q;

  // Beat processing and frame verdict.
  always_comb begin
    pos_d    = pos_q;
    acc_d    = acc_q;
    lo_d     = lo_q;
    sane_d   = sane_q;
    cks_ok_d = cks_ok_q;
    link_d   = link_q;
    seen_d   = seen_q;
    streak_d = streak_q;
    ms_d     = ms_q;
    mem_we   = 1'b0;
    if (cmd_i.take) begin
      if (is_tick) begin
        ms_d = elapsed[16] ? ibus_pkg::SAT_MAX : elapsed[15:0];
        if (sts_o.tick_fire) begin
          link_d = ibus_pkg::LINK_FAILSAFE;
        end
      end else if (pos_q == '0) begin
        if (b == ibus_pkg::HDR_FIRST) begin
          pos_d = 5'd1;
        end
      end else if (pos_q == 5'd1) begin
        if (b == ibus_pkg::HDR_SECOND) begin
          pos_d  = 5'd2;
          acc_d  = ibus_pkg::CKS_START;
          sane_d = 1'b1;
        end else if (b == ibus_pkg::HDR_FIRST) begin
          pos_d = 5'd1;
        end else begin
          pos_d = '0;
        end
      end else begin
        // Body bytes: low bytes wait for their high byte.
        if (!pos_q[0]) begin
          lo_d = b;
        end
        if (pos_q < ibus_pkg::POS_CKS_LO) begin
          acc_d = acc_q - {8'h00, b};
          if (pos_q[0]) begin
            mem_we = 1'b1;
            if ((word < min_q) || (word > max_q)) begin
              sane_d = 1'b0;
            end
          end
        end
        if (pos_q == ibus_pkg::POS_LAST) begin
          cks_ok_d = (acc_q == word);
          pos_d    = '0;
        end else begin
          pos_d = pos_q + 1'b1;
        end
      end
    end
    if (cmd_i.finish) begin
      if (!cks_ok_q) begin
        streak_d = streak_inc;
        if ((streak_inc >= streak_max_q) && (link_q == ibus_pkg::LINK_ACTIVE)) begin
          link_d = ibus_pkg::LINK_DEGRADED;
        end
      end else if (sane_q) begin
        seen_d   = 1'b1;
        ms_d     = '0;
        streak_d = '0;
        link_d   = ibus_pkg::LINK_ACTIVE;
      end
    end
  end

  // Control and link registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      link_q       <= ibus_pkg::LINK_IDLE;
      seen_q       <= 1'b0;
      streak_q     <= '0;
      ms_q         <= '0;
      min_q        <= ibus_pkg::RST_SANITY_MIN;
      max_q        <= ibus_pkg::RST_SANITY_MAX;
      streak_max_q <= ibus_pkg::RST_MAX_STREAK;
      timeout_q    <= ibus_pkg::RST_TIMEOUT;
    end else begin
      pos_q    <= pos_d;
      link_q   <= link_d;
      seen_q   <= seen_d;
      streak_q <= streak_d;
      ms_q     <= ms_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          ibus_pkg::CFG_SANITY_MIN: min_q        <= cfg_data_i;
          ibus_pkg::CFG_SANITY_MAX: max_q        <= cfg_data_i;
          ibus_pkg::CFG_MAX_STREAK: streak_max_q <= cfg_data_i;
          ibus_pkg::CFG_TIMEOUT:    timeout_q    <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Frame payload registers.
  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    lo_q     <= lo_d;
    sane_q   <= sane_d;
    cks_ok_q <= cks_ok_d;
  end

  // Channel store, written as each channel word completes, read with a register.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      chan_mem[mem_waddr] <= word;
    end
    rd_q <= chan_mem[cmd_i.chan_idx];
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.result_kind <= cmd_i.out_kind;
      out_q.last        <= cmd_i.out_last;
      out_q.link_state  <= link_q;
      out_q.fail_streak <= streak_q;
      if (cmd_i.out_kind == ibus_pkg::RES_CHANNEL) begin
        out_q.channel_index <= cmd_i.chan_idx;
        out_q.channel_value <= rd_q;
      end else begin
        out_q.channel_index <= '0;
        out_q.channel_value <= '0;
      end
    end
  end

  assign out_data_o = out_q;

endmodule

// File: rtl/core/ibus_frame_receiver.sv
// Top level of the 14-channel servo frame receiver.
`timescale 1ns / 1ps

// Takes one beat per cycle while idle, a received byte or a millisecond tick,
// and answers with result beats through a single output register. Plain bytes
// and ticks that raise nothing are taken back to back, one per cycle. A tick
// that trips the timeout passes through a status state, which loads its status
// beat into the output register. The 32nd byte of a frame leads to a verdict
// state and then to a status state that offers a checksum or window status
// beat; a good frame instead streams its 14 channel beats through a read state
// and an emit state each, as each word is read from the registered channel
// store before it is offered. New input waits while a frame or a status beat
// is being produced, and a stalled output holds the block in that state. The
// checksum and the window check are built up while bytes arrive. The
// configuration port is always ready; write it only while the block is quiet.
module ibus_frame_receiver (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  ibus_pkg::in_item_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output ibus_pkg::out_item_t            out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ibus_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]                    cfg_data_i
);

  ibus_pkg::cmd_t cmd;
  ibus_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  ibus_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ibus_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

endmodule

// File: rtl/core/ibus_checker.sv
// Port-level checks of the servo frame receiver, bound to its top level.
`timescale 1ns / 1ps

module ibus_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input ibus_pkg::in_item_t             in_data_i,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input ibus_pkg::out_item_t            out_data_o,
  input logic                           cfg_valid_i,
  input logic                           cfg_ready_o,
  input logic [ibus_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input logic [15:0]                    cfg_data_i
);

  // A stalled result beat stays offered and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat dropped or changed while stalled");

  // Channel beats only come from a good frame, so the link is active, streak cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.result_kind == ibus_pkg::RES_CHANNEL) |->
    (out_data_o.link_state == ibus_pkg::LINK_ACTIVE) && (out_data_o.fail_streak == 16'd0))
    else $error("channel beat with inactive link or nonzero streak");

  // In a channel run, only the final channel closes the run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.result_kind == ibus_pkg::RES_CHANNEL) |->
    (out_data_o.last == (out_data_o.channel_index == ibus_pkg::LAST_CHAN)))
    else $error("channel run closed at the wrong channel");

  // Status beats stand alone.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.result_kind != ibus_pkg::RES_CHANNEL) |->
    out_data_o.last && (out_data_o.channel_value == 16'd0))
    else $error("status beat not marked last or carries a value");

  // A timeout beat reports a link in failsafe.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.result_kind == ibus_pkg::RES_TIMEOUT) |->
    (out_data_o.link_state == ibus_pkg::LINK_FAILSAFE))
    else $error("timeout beat without failsafe link");

endmodule

bind ibus_frame_receiver ibus_checker u_ibus_checker (.*);

// File: tb/ibus_frame_receiver_tb.sv
// Self-checking testbench for the servo frame receiver: directed and random traffic.
`timescale 1ns / 1ps

module ibus_frame_receiver_tb;

  localparam int QUIET_CYCLES = 40;
  localparam int DRAIN_LIMIT  = 5000;
  localparam int MAX_PRINTS   = 40;

  // Register indexes past the defined set; writes there must change nothing.
  localparam logic [ibus_pkg::CFG_IDX_W-1:0] CFG_UNUSED  = ibus_pkg::CFG_TIMEOUT + 1'b1;
  localparam logic [ibus_pkg::CFG_IDX_W-1:0] CFG_IDX_TOP = {ibus_pkg::CFG_IDX_W{1'b1}};

  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           in_valid_i  = 1'b0;
  logic                           in_ready_o;
  ibus_pkg::in_item_t             in_data_i   = '0;
  logic                           out_valid_o;
  logic                           out_ready_i = 1'b0;
  ibus_pkg::out_item_t            out_data_o;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [ibus_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [15:0]                    cfg_data_i  = '0;

  // Shadow of the receiver state and its registers.
  logic [7:0]      rx_buf [ibus_pkg::FRAME_LENGTH];
  int              rx_pos       = 0;
  ibus_pkg::link_e link         = ibus_pkg::LINK_IDLE;
  bit              had_good     = 1'b0;
  logic [15:0]     cks_streak   = '0;
  logic [15:0]     ms_idle      = '0;
  logic [15:0]     win_lo       = ibus_pkg::RST_SANITY_MIN;
  logic [15:0]     win_hi       = ibus_pkg::RST_SANITY_MAX;
  logic [15:0]     streak_limit = ibus_pkg::RST_MAX_STREAK;
  logic [15:0]     timeout_lim  = ibus_pkg::RST_TIMEOUT;

  ibus_pkg::out_item_t expected_q [$];
  logic [15:0]         chan_vals [ibus_pkg::CHANNEL_COUNT];

  bit calm        = 1'b0;
  int hold_cycles = 0;

  int beats_sent      = 0;
  int results_checked = 0;
  int frames_good     = 0;
  int frames_cks_bad  = 0;
  int frames_rejected = 0;
  int timeouts_seen   = 0;
  int mismatches      = 0;

  ibus_frame_receiver dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Mismatch reporting; the printout is capped, the count is not.
  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) begin
      $display("[%0t] result %0d: %s", $realtime, results_checked, msg);
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    end
  endtask

  // Queues one expected result beat, stamped with the link state after the step.
  function automatic void push_result(input ibus_pkg::res_kind_e kind, input int idx,
                                      input logic [15:0] value, input logic last);
    ibus_pkg::out_item_t item;
    item.result_kind   = kind;
    item.channel_index = idx[ibus_pkg::CHAN_IDX_W-1:0];
    item.channel_value = value;
    item.last          = last;
    item.link_state    = link;
    item.fail_streak   = cks_streak;
    expected_q.push_back(item);
  endfunction

  // Advances the shadow state by one accepted input beat.
  function automatic void predict_beat(input ibus_pkg::in_item_t beat);
    logic [16:0] elapsed;
    logic [15:0] cks;
    logic [15:0] word;
    bit          sane;
    int          i;
    if (beat.kind == ibus_pkg::KIND_TICK) begin
      // Millisecond tick: saturating silence counter and failsafe check.
      elapsed = {1'b0, ms_idle} + 17'd1;
      ms_idle = elapsed[16] ? ibus_pkg::SAT_MAX : elapsed[15:0];
      if (had_good && elapsed > {1'b0, timeout_lim} && link != ibus_pkg::LINK_FAILSAFE) begin
        link = ibus_pkg::LINK_FAILSAFE;
        timeouts_seen++;
        push_result(ibus_pkg::RES_TIMEOUT, 0, '0, 1'b1);
      end
    end else if (rx_pos == 0) begin
      if (beat.byte_value == ibus_pkg::HDR_FIRST) begin
        rx_buf[0] = beat.byte_value;
        rx_pos    = 1;
      end
    end else if (rx_pos == 1) begin
      // A repeated first header byte restarts the sync instead of dropping it.
      if (beat.byte_value == ibus_pkg::HDR_SECOND) begin
        rx_buf[1] = beat.byte_value;
        rx_pos    = 2;
      end else if (beat.byte_value == ibus_pkg::HDR_FIRST) begin
        rx_buf[0] = beat.byte_value;
        rx_pos    = 1;
      end else begin
        rx_pos = 0;
      end
    end else begin
      rx_buf[rx_pos] = beat.byte_value;
      rx_pos++;
      if (rx_pos == ibus_pkg::FRAME_LENGTH) begin
        rx_pos = 0;
        cks    = ibus_pkg::CKS_INIT;
        for (i = 0; i < ibus_pkg::FRAME_LENGTH - 2; i++) begin
          cks = cks - {8'h00, rx_buf[i]};
        end
        if (cks != {rx_buf[ibus_pkg::FRAME_LENGTH-1], rx_buf[ibus_pkg::FRAME_LENGTH-2]}) begin
          if (cks_streak != ibus_pkg::SAT_MAX) cks_streak++;
          if (cks_streak >= streak_limit && link == ibus_pkg::LINK_ACTIVE) begin
            link = ibus_pkg::LINK_DEGRADED;
          end
          frames_cks_bad++;
          push_result(ibus_pkg::RES_CKSUM_FAIL, 0, '0, 1'b1);
        end else begin
          sane = 1'b1;
          for (i = 0; i < ibus_pkg::CHANNEL_COUNT; i++) begin
            word = {rx_buf[3+2*i], rx_buf[2+2*i]};
            if (word < win_lo || word > win_hi) sane = 1'b0;
          end
          if (!sane) begin
            frames_rejected++;
            push_result(ibus_pkg::RES_SANITY, 0, '0, 1'b1);
          end else begin
            had_good   = 1'b1;
            ms_idle    = '0;
            cks_streak = '0;
            link       = ibus_pkg::LINK_ACTIVE;
            frames_good++;
            for (i = 0; i < ibus_pkg::CHANNEL_COUNT; i++) begin
              push_result(ibus_pkg::RES_CHANNEL, i, {rx_buf[3+2*i], rx_buf[2+2*i]},
                          i == ibus_pkg::CHANNEL_COUNT - 1);
            end
          end
        end
      end
    end
  endfunction

  // Offers one input beat, optionally after a random gap, and waits for it.
  task automatic send_beat(input logic kind, input logic [7:0] value);
    ibus_pkg::in_item_t beat;
    int                 gap;
    beat.kind       = kind;
    beat.byte_value = value;
    if (!calm && $urandom_range(5, 0) == 0) begin
      gap = $urandom_range(7, 1);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_beat(beat);
    beats_sent++;
  endtask

  // Sends a whole frame built from chan_vals, with a good or a damaged checksum.
  task automatic send_frame(input bit corrupt);
    logic [7:0]  frame [ibus_pkg::FRAME_LENGTH];
    logic [15:0] cks;
    int          i;
    frame[0] = ibus_pkg::HDR_FIRST;
    frame[1] = ibus_pkg::HDR_SECOND;
    for (i = 0; i < ibus_pkg::CHANNEL_COUNT; i++) begin
      frame[2+2*i] = chan_vals[i][7:0];
      frame[3+2*i] = chan_vals[i][15:8];
    end
    cks = ibus_pkg::CKS_INIT;
    for (i = 0; i < ibus_pkg::FRAME_LENGTH - 2; i++) begin
      cks = cks - {8'h00, frame[i]};
    end
    if (corrupt) cks = cks ^ 16'($urandom_range(65535, 1));
    frame[ibus_pkg::FRAME_LENGTH-2] = cks[7:0];
    frame[ibus_pkg::FRAME_LENGTH-1] = cks[15:8];
    for (i = 0; i < ibus_pkg::FRAME_LENGTH; i++) begin
      send_beat(ibus_pkg::KIND_BYTE, frame[i]);
    end
  endtask

  task automatic fill_channels(input logic [15:0] lo, input logic [15:0] hi);
    int i;
    for (i = 0; i < ibus_pkg::CHANNEL_COUNT; i++) begin
      chan_vals[i] = 16'($urandom_range(hi, lo));
    end
  endtask

  // Drops the input, waits until every expected result is out, then lets the
  // block finish any frame it may still be closing.
  task automatic settle();
    int waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  // One register write; the shadow copy follows the same write.
  task automatic cfg_write(input logic [ibus_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      ibus_pkg::CFG_SANITY_MIN: win_lo       = data;
      ibus_pkg::CFG_SANITY_MAX: win_hi       = data;
      ibus_pkg::CFG_MAX_STREAK: streak_limit = data;
      ibus_pkg::CFG_TIMEOUT:    timeout_lim  = data;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Header hunting: stray bytes, a bad second byte, a restarted sync, and a
  // frame sitting on both edges of the default window.
  task automatic test_header_sync();
    int i;
    repeat (3) send_beat(ibus_pkg::KIND_TICK, 8'hFF);
    send_beat(ibus_pkg::KIND_BYTE, 8'h00);
    send_beat(ibus_pkg::KIND_BYTE, 8'hFF);
    send_beat(ibus_pkg::KIND_BYTE, ibus_pkg::HDR_SECOND);
    send_beat(ibus_pkg::KIND_BYTE, ibus_pkg::HDR_FIRST);
    send_beat(ibus_pkg::KIND_BYTE, ibus_pkg::HDR_SECOND ^ 8'h01);
    send_beat(ibus_pkg::KIND_BYTE, ibus_pkg::HDR_FIRST);
    for (i = 0; i < ibus_pkg::CHANNEL_COUNT; i++) begin
      chan_vals[i] = (i % 2) ? win_hi : win_lo;
    end
    send_frame(1'b0);
  endtask

  // Under a zero streak limit one failed checksum degrades the active link,
  // and the next good frame clears the streak and restores it.
  task automatic test_checksum_streak();
    settle();
    cfg_write(ibus_pkg::CFG_MAX_STREAK, 16'd0);
    fill_channels(win_lo, win_hi);
    send_frame(1'b1);
    send_frame(1'b0);
    settle();
    cfg_write(ibus_pkg::CFG_MAX_STREAK, ibus_pkg::RST_MAX_STREAK);
  endtask

  // Channel window: one channel just below the lower edge rejects the frame.
  task automatic test_channel_window();
    fill_channels(win_lo, win_hi);
    chan_vals[0] = win_lo - 1'b1;
    send_frame(1'b0);
  endtask

  // Failsafe entry with a zero timeout; a second tick raises nothing more.
  task automatic test_failsafe_timeout();
    settle();
    cfg_write(ibus_pkg::CFG_TIMEOUT, 16'd0);
    repeat (2) send_beat(ibus_pkg::KIND_TICK, 8'h00);
  endtask

  // Long receiver hold while a frame and a tick keep coming, so the input
  // side backs up; the good frame also brings the link out of failsafe.
  task automatic test_output_stall();
    settle();
    hold_cycles = 300;
    fill_channels(win_lo, win_hi);
    send_frame(1'b0);
    send_beat(ibus_pkg::KIND_TICK, 8'($urandom));
  endtask

  // Random traffic under a narrower window, mostly well-formed frames.
  task automatic test_random_traffic();
    int pick;
    int k;
    int start_beats;
    settle();
    cfg_write(ibus_pkg::CFG_SANITY_MIN, 16'd1000);
    cfg_write(ibus_pkg::CFG_SANITY_MAX, 16'd2000);
    cfg_write(ibus_pkg::CFG_MAX_STREAK, 16'd2);
    cfg_write(ibus_pkg::CFG_TIMEOUT, 16'd3);
    cfg_write(CFG_UNUSED, 16'($urandom));
    cfg_write(CFG_IDX_TOP, 16'($urandom));
    // The closing stretch runs without any idling on either side.
    calm = 1'b1;
    start_beats = beats_sent;
    while (beats_sent - start_beats < 40) begin
      pick = $urandom_range(99, 0);
      if (pick < 75) begin
        fill_channels(win_lo, win_hi);
        if (pick >= 55 && pick < 65) begin
          k = $urandom_range(ibus_pkg::CHANNEL_COUNT - 1, 0);
          if ($urandom_range(1, 0) == 1) begin
            chan_vals[k] = 16'($urandom_range(win_lo - 1, 0));
          end else begin
            chan_vals[k] = 16'($urandom_range(ibus_pkg::SAT_MAX, win_hi + 1));
          end
        end
        send_frame(pick >= 65);
      end else if (pick < 85) begin
        repeat ($urandom_range(8, 1)) send_beat(ibus_pkg::KIND_TICK, 8'($urandom));
      end else if (pick < 93) begin
        repeat ($urandom_range(4, 1)) send_beat(ibus_pkg::KIND_BYTE, 8'($urandom));
      end else begin
        send_beat(ibus_pkg::KIND_BYTE, ibus_pkg::HDR_FIRST);
        send_beat(ibus_pkg::KIND_BYTE, 8'($urandom));
      end
    end
  endtask

  // Receiver side: random stall bursts, plus a long hold on request.
  initial begin : out_ready_drive
    int stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        hold_cycles--;
      end else if (stall > 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else if (!calm && $urandom_range(4, 0) == 0) begin
        out_ready_i <= 1'b0;
        stall = $urandom_range(6, 0);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Every result beat is compared against the oldest expectation.
  always @(posedge clk_i) begin : result_check
    ibus_pkg::out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_checked++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat of kind %0d",
                                  out_data_o.result_kind));
      end else begin
        want = expected_q.pop_front();
        check_field("result_kind", 16'(out_data_o.result_kind), 16'(want.result_kind));
        check_field("channel_index", 16'(out_data_o.channel_index),
                    16'(want.channel_index));
        check_field("channel_value", out_data_o.channel_value, want.channel_value);
        check_field("last", 16'(out_data_o.last), 16'(want.last));
        check_field("link_state", 16'(out_data_o.link_state), 16'(want.link_state));
        check_field("fail_streak", out_data_o.fail_streak, want.fail_streak);
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("Run stopped by the watchdog after %0d input beats.", beats_sent);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : run
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_header_sync();
    test_checksum_streak();
    test_channel_window();
    test_failsafe_timeout();
    test_output_stall();
    test_random_traffic();
    settle();
    if (expected_q.size() != 0) begin
      report_mismatch($sformatf("%0d expected result beats never arrived",
                                expected_q.size()));
    end
    $display("Covered %0d input beats: %0d good frames, %0d checksum failures,",
             beats_sent, frames_good, frames_cks_bad);
    $display("%0d window rejects, %0d timeouts; %0d result beats checked, %0d mismatches.",
             frames_rejected, timeouts_seen, results_checked, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
